// ----- hdl/jhmp_pkg.sv -----
`default_nettype none
package jhmp_pkg;

  typedef enum logic [2:0] {
    PH_START0,
    PH_START1,
    PH_HUNT,
    PH_TYPE,
    PH_LENHI,
    PH_LENLO,
    PH_PAYLOAD,
    PH_DRAIN
  } phase_e;

  typedef enum logic [1:0] {
    ST_SOS       = 2'd0,
    ST_BAD_START = 2'd1,
    ST_EOF       = 2'd2
  } status_e;

  localparam logic [7:0] ByteFill  = 8'hFF;
  localparam logic [7:0] ByteSoi   = 8'hD8;
  localparam logic [7:0] MarkSof0  = 8'hC0;
  localparam logic [7:0] MarkApp0  = 8'hE0;
  localparam logic [7:0] MarkSos   = 8'hDA;
  localparam logic [7:0] MarkTem   = 8'h00;
  localparam logic [7:0] MarkRes01 = 8'h01;
  // D0..D7 share these upper five bits
  localparam logic [4:0] MarkRstHi = 5'b11010;

  localparam int unsigned DataW = 74;
  localparam int unsigned TdataW = 80;

  typedef struct packed {
    logic [15:0] y_density;
    logic [15:0] x_density;
    logic [7:0]  density_units;
    logic        app0_seen;
    logic        frame_seen;
    logic [15:0] image_height;
    logic [15:0] image_width;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/jhmp_core.sv -----
`default_nettype none
module jhmp_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              eof_i,
  output      logic              emit_o,
  output      jhmp_pkg::status_e status_o,
  output      jhmp_pkg::result_t res_o
);

  jhmp_pkg::phase_e phase_q, phase_d;
  logic [7:0]  kind_q, kind_d;
  logic [15:0] off_q, off_d;
  logic [15:0] len_q, len_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [7:0]  units_q, units_d;
  logic [15:0] xdens_q, xdens_d;
  logic [15:0] ydens_q, ydens_d;
  logic [1:0]  seen_q, seen_d;
  logic        rep_q, rep_d;

  always_comb begin
    logic [15:0] len_lo;
    logic [15:0] off_nx;
    logic        standalone;
    // values after this byte, before any end-of-file re-arm
    jhmp_pkg::phase_e ph;
    logic [7:0]  kd;
    logic [15:0] of, ln, wd, ht, xd, yd;
    logic [7:0]  un;
    logic [1:0]  sn;
    logic        rp;

    len_lo     = {len_q[15:8], byte_i};
    off_nx     = off_q + 16'd1;
    standalone = (byte_i == jhmp_pkg::MarkTem) || (byte_i == jhmp_pkg::MarkRes01) ||
                 (byte_i[7:3] == jhmp_pkg::MarkRstHi);
    ph = phase_q; kd = kind_q; of = off_q; ln = len_q;
    wd = width_q; ht = height_q; un = units_q; xd = xdens_q; yd = ydens_q;
    sn = seen_q; rp = rep_q;
    emit_o   = 1'b0;
    status_o = jhmp_pkg::ST_EOF;

    case (phase_q)
      jhmp_pkg::PH_START0: begin
        if (byte_i == jhmp_pkg::ByteFill) begin
          ph = jhmp_pkg::PH_START1;
        end else begin
          emit_o = 1'b1; status_o = jhmp_pkg::ST_BAD_START;
          rp = 1'b1; ph = jhmp_pkg::PH_DRAIN;
        end
      end
      jhmp_pkg::PH_START1: begin
        if (byte_i == jhmp_pkg::ByteSoi) begin
          ph = jhmp_pkg::PH_HUNT;
        end else begin
          emit_o = 1'b1; status_o = jhmp_pkg::ST_BAD_START;
          rp = 1'b1; ph = jhmp_pkg::PH_DRAIN;
        end
      end
      jhmp_pkg::PH_HUNT: begin
        if (byte_i == jhmp_pkg::ByteFill) ph = jhmp_pkg::PH_TYPE;
      end
      jhmp_pkg::PH_TYPE: begin
        if (byte_i != jhmp_pkg::ByteFill) begin
          kd = byte_i;
          if (byte_i == jhmp_pkg::MarkSos) begin
            emit_o = 1'b1; status_o = jhmp_pkg::ST_SOS;
            rp = 1'b1; ph = jhmp_pkg::PH_DRAIN;
          end else if (standalone) begin
            ph = jhmp_pkg::PH_HUNT;
          end else begin
            ph = jhmp_pkg::PH_LENHI;
          end
        end
      end
      jhmp_pkg::PH_LENHI: begin
        ln = {byte_i, 8'h00};
        of = 16'd1;
        ph = jhmp_pkg::PH_LENLO;
      end
      jhmp_pkg::PH_LENLO: begin
        ln = (len_lo < 16'd2) ? 16'd2 : len_lo;
        of = 16'd2;
        if (kind_q == jhmp_pkg::MarkSof0) begin
          wd = '0; ht = '0; sn[0] = 1'b1;
        end else if (kind_q == jhmp_pkg::MarkApp0) begin
          un = '0; xd = '0; yd = '0; sn[1] = 1'b1;
        end
        ph = (len_lo > 16'd2) ? jhmp_pkg::PH_PAYLOAD : jhmp_pkg::PH_HUNT;
      end
      jhmp_pkg::PH_PAYLOAD: begin
        if (kind_q == jhmp_pkg::MarkSof0) begin
          if (off_q == 16'd3) ht[15:8] = byte_i;
          if (off_q == 16'd4) ht[7:0]  = byte_i;
          if (off_q == 16'd5) wd[15:8] = byte_i;
          if (off_q == 16'd6) wd[7:0]  = byte_i;
        end else if (kind_q == jhmp_pkg::MarkApp0) begin
          if (off_q == 16'd9)  un       = byte_i;
          if (off_q == 16'd10) xd[15:8] = byte_i;
          if (off_q == 16'd11) xd[7:0]  = byte_i;
          if (off_q == 16'd12) yd[15:8] = byte_i;
          if (off_q == 16'd13) yd[7:0]  = byte_i;
        end
        if (off_nx >= len_q) begin
          ph = jhmp_pkg::PH_HUNT; of = '0;
        end else begin
          of = off_nx;
        end
      end
      default: ph = jhmp_pkg::PH_DRAIN;
    endcase

    if (eof_i && !emit_o && !rp) begin
      emit_o = 1'b1; status_o = jhmp_pkg::ST_EOF;
    end

    res_o.image_width   = wd;
    res_o.image_height  = ht;
    res_o.frame_seen    = sn[0];
    res_o.app0_seen     = sn[1];
    res_o.density_units = un;
    res_o.x_density     = xd;
    res_o.y_density     = yd;
    emit_o = emit_o & step_i;

    if (eof_i) begin
      // end of file re-arms for the next file
      phase_d = jhmp_pkg::PH_START0; kind_d = '0; off_d = '0; len_d = '0;
      width_d = '0; height_d = '0; units_d = '0; xdens_d = '0; ydens_d = '0;
      seen_d = '0; rep_d = 1'b0;
    end else begin
      phase_d = ph; kind_d = kd; off_d = of; len_d = ln;
      width_d = wd; height_d = ht; units_d = un; xdens_d = xd; ydens_d = yd;
      seen_d = sn; rep_d = rp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= jhmp_pkg::PH_START0;
      kind_q   <= '0;
      off_q    <= '0;
      len_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      units_q  <= '0;
      xdens_q  <= '0;
      ydens_q  <= '0;
      seen_q   <= '0;
      rep_q    <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      off_q    <= off_d;
      len_q    <= len_d;
      width_q  <= width_d;
      height_q <= height_d;
      units_q  <= units_d;
      xdens_q  <= xdens_d;
      ydens_q  <= ydens_d;
      seen_q   <= seen_d;
      rep_q    <= rep_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/jpeg_header_marker_parser.sv -----
// Path: a word accepted into the input register waits there until the result slot is free;
//   it is then parsed, and a result it causes is registered for the master side.
// Throughput: 1 word per cycle unless a held result stalls; the parser is combinational.
// Reset (rst_ni low, async): parser re-armed for a new file, both registers emptied.
`default_nettype none
module jpeg_header_marker_parser (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output      logic                             s_axis_tready_o,
  input  wire logic [7:0]                       s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic                             s_axis_tlast_i,  // end_of_file
  output      logic                             m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [15:0] image_width, [31:16] image_height, [32] frame_seen, [33] app0_seen,
  // [41:34] density_units, [57:42] x_density, [73:58] y_density, [79:74] zero
  output      logic [jhmp_pkg::TdataW-1:0]      m_axis_tdata_o,
  output      logic [1:0]                       m_axis_tuser_o   // [1:0] status
);

  // input register: one word waiting for the parser
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_eof_q;

  // result register
  logic              out_valid_q, out_valid_d;
  jhmp_pkg::result_t out_res_q;
  jhmp_pkg::status_e out_st_q;

  logic              step;
  logic              emit;
  jhmp_pkg::status_e st;
  jhmp_pkg::result_t res;

  // parse the held word only when a result it may cause has a free slot
  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;

  jhmp_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .eof_i   (in_eof_q),
    .emit_o  (emit),
    .status_o(st),
    .res_o   (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready_o) in_valid_d = s_axis_tvalid_i;

    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = emit;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_eof_q  <= s_axis_tlast_i;
    end
    if (emit) begin
      out_res_q <= res;
      out_st_q  <= st;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_st_q;
  assign m_axis_tdata_o  = {{(jhmp_pkg::TdataW - jhmp_pkg::DataW){1'b0}}, out_res_q};

  // stalled input means both stages are occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  // a nonzero width only comes from an SOF0 segment
  a_width_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[15:0] != 16'd0)) |-> m_axis_tdata_o[32])
    else $error("width reported without SOF0");

  // nonzero density units only come from an APP0 segment
  a_units_app0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[41:34] != 8'd0)) |-> m_axis_tdata_o[33])
    else $error("density units reported without APP0");

endmodule
`default_nettype wire
